### rtl/core/tcce_pkg.sv
package tcce_pkg;

   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int POS_W       = 11;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int COLOUR_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;
   localparam int TAB_STOP    = 8;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic [ATTR_W-1:0]   RESET_ATTR       = 8'h07;
   localparam logic [COLOUR_W-1:0] RESET_FOREGROUND = 4'h7;
   localparam logic [COLOUR_W-1:0] RESET_BACKGROUND = 4'h0;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 1'b1;

   typedef enum logic [2:0] {
      CMD_PRINT,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_RETURN,
      CMD_TAB,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CHAR_W-1:0]        char_code;
      logic [ROW_FIELD_W-1:0]   read_row;
      logic [COL_FIELD_W-1:0]   read_column;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ
   } back_state_type;

endpackage

### rtl/core/tcce_front.sv
module tcce_front #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tcce_pkg::OP_W-1:0]         req_tuser,  // operation
   // char_code, read_row, read_column, zero fill
   input  logic [tcce_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              hold,
   output tcce_pkg::queue_head_type          head,
   input  logic                              pop
);

   tcce_pkg::cmd_type entry_ff [2];
   tcce_pkg::cmd_type cmd;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              in_range;

   always_comb begin
      cmd.char_code   = req_tdata[7:0];
      cmd.read_row    = req_tdata[12:8];
      cmd.read_column = req_tdata[19:13];
      in_range = (32'(cmd.read_row) < 32'(SCREEN_ROWS)) &&
                 (32'(cmd.read_column) < 32'(SCREEN_COLUMNS));
      case (req_tuser)
         tcce_pkg::OP_PUT: begin
            case (cmd.char_code)
               tcce_pkg::CHAR_NEWLINE:   cmd.kind = tcce_pkg::CMD_NEWLINE;
               tcce_pkg::CHAR_BACKSPACE: cmd.kind = tcce_pkg::CMD_BACKSPACE;
               tcce_pkg::CHAR_RETURN:    cmd.kind = tcce_pkg::CMD_RETURN;
               tcce_pkg::CHAR_TAB:       cmd.kind = tcce_pkg::CMD_TAB;
               default:                  cmd.kind = tcce_pkg::CMD_PRINT;
            endcase
         end
         tcce_pkg::OP_CLEAR: cmd.kind = tcce_pkg::CMD_CLEAR;
         // A read off the screen changes nothing and returns a zero cell value.
         tcce_pkg::OP_READ:  cmd.kind = in_range ? tcce_pkg::CMD_READ : tcce_pkg::CMD_NOP;
         default:            cmd.kind = tcce_pkg::CMD_NOP;
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !hold;
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### rtl/core/tcce_back.sv
module tcce_back #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcce_pkg::queue_head_type              head,
   output logic                                  pop,
   output logic                                  init_busy,
   input  logic [tcce_pkg::ATTR_W-1:0]           attribute,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tcce_pkg::ROW_FIELD_W-1:0]      rsp_row,
   output logic [tcce_pkg::COL_FIELD_W-1:0]      rsp_column,
   output logic [tcce_pkg::POS_W-1:0]            rsp_position,
   output logic [tcce_pkg::CELL_W-1:0]           rsp_cell
);

   localparam int RW    = $clog2(SCREEN_ROWS);
   localparam int CW    = $clog2(SCREEN_COLUMNS);
   localparam int RW1   = RW + 1;
   localparam int CW1   = CW + 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = SCREEN_ROWS * (2 ** CW);
   localparam logic [RW-1:0]  LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0]  LAST_COL = CW'(SCREEN_COLUMNS - 1);
   localparam logic [RW1-1:0] ROWS_W   = RW1'(SCREEN_ROWS);
   localparam logic [CW1-1:0] COLS_W   = CW1'(SCREEN_COLUMNS);
   localparam logic [CW1-1:0] TAB_ADD  = CW1'(tcce_pkg::TAB_STOP);
   localparam logic [CW1-1:0] TAB_MASK = ~CW1'(tcce_pkg::TAB_STOP - 1);

   // Rows are stored in a ring: top_ff names the physical row shown first.
   logic [tcce_pkg::CELL_W-1:0] screen_ff [DEPTH];
   logic [tcce_pkg::CELL_W-1:0] rd_data_ff;

   tcce_pkg::back_state_type state_ff, state_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   top_ff, top_in;
   logic [RW-1:0]   fill_row_ff, fill_row_in;
   logic [CW-1:0]   fill_col_ff, fill_col_in;
   logic            fill_all_ff, fill_all_in;
   logic [tcce_pkg::ATTR_W-1:0] fill_attr_ff, fill_attr_in;
   logic            init_ff, init_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [tcce_pkg::ROW_FIELD_W-1:0] rsp_row_ff;
   logic [tcce_pkg::COL_FIELD_W-1:0] rsp_col_ff;
   logic [tcce_pkg::POS_W-1:0]       rsp_pos_ff;
   logic [tcce_pkg::CELL_W-1:0]      rsp_cell_ff;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [tcce_pkg::CELL_W-1:0] mem_wdata;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            load;
   logic            load_cell;
   logic            slot_free;

   logic [CW1-1:0]  tab_sum;
   logic [RW-1:0]   nxt_row;
   logic [CW-1:0]   nxt_col;
   logic            inc_row;
   logic            scroll;
   logic [RW1-1:0]  cur_sum, rd_sum;
   logic [RW-1:0]   cur_phys, rd_phys;
   logic [RW-1:0]   out_row;
   logic [CW-1:0]   out_col;
   logic [31:0]     pos_full;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Cursor movement for the item at the head of the queue.
   always_comb begin
      tab_sum = ({1'b0, col_ff} + TAB_ADD) & TAB_MASK;
      nxt_row = row_ff;
      nxt_col = col_ff;
      inc_row = 1'b0;
      case (head.cmd.kind)
         tcce_pkg::CMD_NEWLINE: begin
            nxt_col = '0;
            inc_row = 1'b1;
         end
         tcce_pkg::CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               nxt_col = col_ff - 1'b1;
            end else if (row_ff != '0) begin
               nxt_row = row_ff - 1'b1;
               nxt_col = LAST_COL;
            end
         end
         tcce_pkg::CMD_RETURN: nxt_col = '0;
         tcce_pkg::CMD_TAB: begin
            if (tab_sum >= COLS_W) begin
               nxt_col = '0;
               inc_row = 1'b1;
            end else begin
               nxt_col = tab_sum[CW-1:0];
            end
         end
         tcce_pkg::CMD_PRINT: begin
            if (col_ff == LAST_COL) begin
               nxt_col = '0;
               inc_row = 1'b1;
            end else begin
               nxt_col = col_ff + 1'b1;
            end
         end
         tcce_pkg::CMD_CLEAR: begin
            nxt_row = '0;
            nxt_col = '0;
         end
         default: begin
         end
      endcase
      scroll = inc_row && (row_ff == LAST_ROW);
      if (inc_row && !scroll) begin
         nxt_row = row_ff + 1'b1;
      end
   end

   // Logical to physical row mapping.
   always_comb begin
      cur_sum  = {1'b0, top_ff} + {1'b0, row_ff};
      cur_phys = (cur_sum >= ROWS_W) ? RW'(cur_sum - ROWS_W) : cur_sum[RW-1:0];
      rd_sum   = {1'b0, top_ff} + RW1'(head.cmd.read_row);
      rd_phys  = (rd_sum >= ROWS_W) ? RW'(rd_sum - ROWS_W) : rd_sum[RW-1:0];
      rd_addr  = {rd_phys, CW'(head.cmd.read_column)};
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      fill_row_in  = fill_row_ff;
      fill_col_in  = fill_col_ff;
      fill_all_in  = fill_all_ff;
      fill_attr_in = fill_attr_ff;
      mem_we       = 1'b0;
      mem_waddr    = {fill_row_ff, fill_col_ff};
      mem_wdata    = {fill_attr_ff, tcce_pkg::CHAR_SPACE};
      rd_en        = 1'b0;
      pop          = 1'b0;
      load         = 1'b0;
      load_cell    = 1'b0;
      case (state_ff)
         tcce_pkg::ST_FILL: begin
            mem_we = 1'b1;
            if (fill_col_ff == LAST_COL) begin
               fill_col_in = '0;
               if (fill_all_ff && (fill_row_ff != LAST_ROW)) begin
                  fill_row_in = fill_row_ff + 1'b1;
               end else begin
                  state_in = tcce_pkg::ST_IDLE;
               end
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         tcce_pkg::ST_IDLE: begin
            if (head.valid && (head.cmd.kind == tcce_pkg::CMD_READ)) begin
               rd_en    = 1'b1;
               pop      = 1'b1;
               state_in = tcce_pkg::ST_READ;
            end else if (head.valid && slot_free) begin
               pop    = 1'b1;
               load   = 1'b1;
               row_in = nxt_row;
               col_in = nxt_col;
               if (head.cmd.kind == tcce_pkg::CMD_PRINT) begin
                  mem_we    = 1'b1;
                  mem_waddr = {cur_phys, col_ff};
                  mem_wdata = {attribute, head.cmd.char_code};
               end
               if (scroll) begin
                  // The old top row becomes the new bottom row and is blanked.
                  top_in       = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                  fill_row_in  = top_ff;
                  fill_col_in  = '0;
                  fill_all_in  = 1'b0;
                  fill_attr_in = attribute;
                  state_in     = tcce_pkg::ST_FILL;
               end else if (head.cmd.kind == tcce_pkg::CMD_CLEAR) begin
                  top_in       = '0;
                  fill_row_in  = '0;
                  fill_col_in  = '0;
                  fill_all_in  = 1'b1;
                  fill_attr_in = attribute;
                  state_in     = tcce_pkg::ST_FILL;
               end
            end
         end
         tcce_pkg::ST_READ: begin
            if (slot_free) begin
               load      = 1'b1;
               load_cell = 1'b1;
               state_in  = tcce_pkg::ST_IDLE;
            end
         end
         default: state_in = tcce_pkg::ST_IDLE;
      endcase
      init_in      = init_ff && (state_in == tcce_pkg::ST_FILL);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_comb begin
      out_row  = (state_ff == tcce_pkg::ST_READ) ? row_ff : nxt_row;
      out_col  = (state_ff == tcce_pkg::ST_READ) ? col_ff : nxt_col;
      pos_full = 32'(out_row) * 32'(SCREEN_COLUMNS) + 32'(out_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcce_pkg::ST_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         fill_row_ff  <= '0;
         fill_col_ff  <= '0;
         fill_all_ff  <= 1'b1;
         fill_attr_ff <= tcce_pkg::RESET_ATTR;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         fill_row_ff  <= fill_row_in;
         fill_col_ff  <= fill_col_in;
         fill_all_ff  <= fill_all_in;
         fill_attr_ff <= fill_attr_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff  <= tcce_pkg::ROW_FIELD_W'(out_row);
         rsp_col_ff  <= tcce_pkg::COL_FIELD_W'(out_col);
         rsp_pos_ff  <= pos_full[tcce_pkg::POS_W-1:0];
         rsp_cell_ff <= load_cell ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   assign init_busy    = init_ff;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_column   = rsp_col_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_cell     = rsp_cell_ff;

   cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(SCREEN_ROWS)) && (32'(col_ff) < 32'(SCREEN_COLUMNS)))
      else $error("cursor left the screen");

   top_row_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) < 32'(SCREEN_ROWS))
      else $error("ring top row out of range");

   no_pop_while_filling: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcce_pkg::ST_FILL) |-> !pop)
      else $error("queue popped during a fill sweep");

   read_then_wait: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == tcce_pkg::ST_READ) && !load_cell || load_cell)
      else $error("read issued without a read wait");

   load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("response overwritten before it was taken");

endmodule

### rtl/core/text_console_character_engine.sv
// A put, clear or off-screen read passes the request queue and the response register; an
// on-screen read also passes the cell memory's registered read port, in state ST_READ.
// Throughput: one item per cycle while no fill runs and responses are taken; a read also
// waits in ST_READ. No item leaves the queue while a scroll blanks SCREEN_COLUMNS cells or
// a clear SCREEN_ROWS * SCREEN_COLUMNS cells. Reset is synchronous; afterwards a pass over
// all cells blanks the screen to attribute 0x07, and req_tready stays low until it ends.
module text_console_character_engine #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcce_pkg::OP_W-1:0]           req_tuser,  // operation
   // char_code, read_row, read_column, zero fill
   input  logic [tcce_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cursor_row, cursor_column, cursor_position, cell_value, zero fill
   output logic [tcce_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcce_pkg::COLOUR_W-1:0]       csr_data
);

   logic [tcce_pkg::COLOUR_W-1:0] fg_ff, fg_in;
   logic [tcce_pkg::COLOUR_W-1:0] bg_ff, bg_in;
   tcce_pkg::queue_head_type      head;
   logic                          pop;
   logic                          init_busy;
   logic [tcce_pkg::ROW_FIELD_W-1:0] rsp_row;
   logic [tcce_pkg::COL_FIELD_W-1:0] rsp_column;
   logic [tcce_pkg::POS_W-1:0]       rsp_position;
   logic [tcce_pkg::CELL_W-1:0]      rsp_cell;

   assign csr_ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid) begin
         case (csr_index)
            tcce_pkg::CSR_FOREGROUND: fg_in = csr_data;
            tcce_pkg::CSR_BACKGROUND: bg_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tcce_pkg::RESET_FOREGROUND;
         bg_ff <= tcce_pkg::RESET_BACKGROUND;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   tcce_front #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .hold       (init_busy),
      .head       (head),
      .pop        (pop)
   );

   tcce_back #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .init_busy    (init_busy),
      .attribute    ({bg_ff, fg_ff}),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_row      (rsp_row),
      .rsp_column   (rsp_column),
      .rsp_position (rsp_position),
      .rsp_cell     (rsp_cell)
   );

   assign rsp_tdata = {1'b0, rsp_cell, rsp_position, rsp_column, rsp_row};

endmodule
